@@ rtl/core/wide_float_add_sub_256_defines.svh @@
// assertion macros for the wide float adder
`ifndef WIDE_FLOAT_ADD_SUB_256_DEFINES_SVH
`define WIDE_FLOAT_ADD_SUB_256_DEFINES_SVH
// implication checked on every clock edge outside reset
`define WFA_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
// next-cycle implication
`define WFA_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`endif

@@ rtl/core/wfa_pkg.sv @@
// package for the wide float adder: types and constants
package wfa_pkg;
	localparam logic [10:0] EXP_ONES = 11'h7FF;
	localparam logic [63:0] DEF_NAN = 64'h7FF8000000000000;
	localparam logic [63:0] QUIET = 64'h0008000000000000;

	typedef enum logic [1:0] {
		R_ARITH,
		R_PASS,
		R_ZERO
	} rkind_t;

	// stage 1 -> stage 2: aligned operands
	typedef struct packed {
		rkind_t rk;
		logic [255:0] pass;
		logic sub;
		logic s1;
		logic s2;
		logic [11:0] e1;
		logic [255:0] m1;
		logic [255:0] m2;
	} s1_t;

	// stage 2 -> stage 3: raw sum
	typedef struct packed {
		rkind_t rk;
		logic [255:0] pass;
		logic rs;
		logic [12:0] e;
		logic [255:0] r;
		logic [8:0] lz;
	} s2_t;

	// leading zero count of a 256-bit word
	function automatic logic [8:0] clz256(input logic [255:0] v);
		logic [8:0] n;
		logic found;
		n = 9'd256;
		found = 1'b0;
		for (int i = 255; i >= 0; i--) begin
			if (!found && v[i]) begin
				n = 9'(255 - i);
				found = 1'b1;
			end
		end
		return n;
	endfunction
endpackage

@@ rtl/core/wfa_align.sv @@
// stage 1: special cases, operand swap and alignment shift
module wfa_align import wfa_pkg::*; (
	input logic clk,
	input logic kind,
	input logic [255:0] a,
	input logic [255:0] b_in,
	output s1_t st
);
	logic [255:0] b;
	logic [10:0] ea, eb;
	logic za, zb, nan_a, nan_b;
	logic [255:0] ma, mb, msh;
	logic swap;
	logic [10:0] diff;
	logic [63:0] t;
	s1_t n;

	always_comb begin
		b = b_in;
		b[255] = b_in[255] ^ kind;
		ea = a[254:244];
		eb = b[254:244];
		za = (a[254:0] == '0);
		zb = (b[254:0] == '0);
		nan_a = (ea == EXP_ONES) && (a[243:192] != '0);
		nan_b = (eb == EXP_ONES) && (b[243:192] != '0);
		ma = {1'b1, a[243:0], 11'd0};
		mb = {1'b1, b[243:0], 11'd0};
		swap = eb > ea;
		diff = swap ? eb - ea : ea - eb;
		msh = (swap ? ma : mb) >> diff;
		t = '0;
		n = '0;
		n.rk = R_PASS;
		n.sub = a[255] ^ b[255];
		n.s1 = swap ? b[255] : a[255];
		n.s2 = swap ? a[255] : b[255];
		n.e1 = {1'b0, swap ? eb : ea};
		n.m1 = swap ? mb : ma;
		n.m2 = msh;
		if (za) n.pass = b;
		else if (zb) n.pass = a;
		else if (ea == EXP_ONES || eb == EXP_ONES) begin
			if (nan_a) t = a[255:192] | QUIET;
			else if (nan_b) t = b[255:192] | QUIET;
			else if (ea == EXP_ONES && eb == EXP_ONES)
				t = (a[255] ^ b[255]) ? DEF_NAN : a[255:192];
			else t = (ea == EXP_ONES) ? a[255:192] : b[255:192];
			n.pass = {t, 192'd0};
		end else if (diff >= 11'd256) n.pass = swap ? b : a;
		else n.rk = R_ARITH;
	end

	always_ff @(posedge clk) begin
		st <= n;
	end
endmodule

@@ rtl/core/wfa_addsub.sv @@
// stage 2: add or subtract magnitudes and count leading zeros
module wfa_addsub import wfa_pkg::*; (
	input logic clk,
	input s1_t st_in,
	output s2_t st
);
	logic [256:0] sum;
	logic ge;
	logic [255:0] d;
	s2_t n;

	always_comb begin
		n = '0;
		n.rk = st_in.rk;
		n.pass = st_in.pass;
		sum = {1'b0, st_in.m1} + {1'b0, st_in.m2};
		ge = st_in.m1 >= st_in.m2;
		d = ge ? st_in.m1 - st_in.m2 : st_in.m2 - st_in.m1;
		n.e = {1'b0, st_in.e1};
		if (!st_in.sub) begin
			n.rs = st_in.s1;
			if (sum[256]) begin
				n.r = sum[256:1];
				n.e = {1'b0, st_in.e1} + 13'd1;
			end else n.r = sum[255:0];
			n.lz = '0;
		end else begin
			n.rs = ge ? st_in.s1 : st_in.s2;
			n.r = d;
			n.lz = clz256(d);
			if (st_in.rk == R_ARITH && d == '0) n.rk = R_ZERO;
		end
	end

	always_ff @(posedge clk) begin
		st <= n;
	end
endmodule

@@ rtl/core/wfa_norm.sv @@
// stage 3: normalize and pack
module wfa_norm import wfa_pkg::*; (
	input logic clk,
	input s2_t st_in,
	output logic [255:0] res
);
	logic [255:0] m;
	logic [13:0] be;
	logic [255:0] n;

	always_comb begin
		m = st_in.r << st_in.lz;
		// biased exponent: e1 field already biased; subtract lz
		be = {1'b0, st_in.e} - {5'd0, st_in.lz};
		unique case (st_in.rk)
			R_PASS: n = st_in.pass;
			R_ZERO: n = '0;
			default: begin
				if (!be[13] && be >= 14'd2047) n = {st_in.rs, EXP_ONES, 244'd0};
				else if (be[13] || be == '0) n = {st_in.rs, 255'd0};
				else n = {st_in.rs, be[10:0], m[254:11]};
			end
		endcase
	end

	always_ff @(posedge clk) begin
		res <= n;
	end
endmodule

@@ rtl/core/wide_float_add_sub_256.sv @@
// top level of the 256-bit wide float adder and subtractor
// Three-stage pipeline (align, add/subtract with leading-zero count,
// normalize and pack). busy is always low: a request is taken in every
// cycle that start is high; its result leaves the normalize register on
// the sum ports with done high for one cycle. The receiver has no
// way to stall, so results must be captured when done is high. Every bit
// shifted out during alignment or normalization is truncated.
`include "wide_float_add_sub_256_defines.svh"
module wide_float_add_sub_256 import wfa_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic start,
	output logic busy,
	output logic done,
	input logic kind,
	input logic [63:0] a_top,
	input logic [63:0] a_ext_high,
	input logic [63:0] a_ext_mid,
	input logic [63:0] a_ext_low,
	input logic [63:0] b_top,
	input logic [63:0] b_ext_high,
	input logic [63:0] b_ext_mid,
	input logic [63:0] b_ext_low,
	output logic [63:0] sum_top,
	output logic [63:0] sum_ext_high,
	output logic [63:0] sum_ext_mid,
	output logic [63:0] sum_ext_low
);
	s1_t st1;
	s2_t st2;
	logic [255:0] res;
	logic v_s1, v_s2, v_s3;

	// pipeline never stalls
	assign busy = 1'b0;

	// valid bits travel alongside the data stages
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= start;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	wfa_align u_align (
		.clk(clk), .kind(kind),
		.a({a_top, a_ext_high, a_ext_mid, a_ext_low}),
		.b_in({b_top, b_ext_high, b_ext_mid, b_ext_low}),
		.st(st1)
	);
	wfa_addsub u_addsub (.clk(clk), .st_in(st1), .st(st2));
	wfa_norm u_norm (.clk(clk), .st_in(st2), .res(res));

	assign done = v_s3;
	assign sum_top = res[255:192];
	assign sum_ext_high = res[191:128];
	assign sum_ext_mid = res[127:64];
	assign sum_ext_low = res[63:0];

	// a request valid in the second stage is followed by done
	`WFA_ASSERT_NXT(a_lat, v_s2, done)
	// a result only follows an earlier request
	`WFA_ASSERT_IMP(a_cause, done, $past(start, 3))
	// busy never blocks a request
	`WFA_ASSERT_IMP(a_busy, start, !busy)
endmodule
